// File: hw/rtl/sssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_pkg - shared types and helpers for the seven-segment scan driver
// word layouts, action and register codes, character decode, decimal split
// ----------------------------------------------------------------------------
package sssd_pkg;

	localparam int unsigned DWELL_MAX_DEF = 1000;
	localparam int unsigned NUM_DIGITS    = 4;
	localparam int unsigned CFG_IDX_W     = 1;
	localparam int unsigned CFG_DATA_W    = 4;

	typedef enum logic [2:0] {
		ACT_TICK        = 3'd0,
		ACT_SET_CHAR    = 3'd1,
		ACT_SET_HOURS   = 3'd2,
		ACT_SET_MINUTES = 3'd3,
		ACT_SET_DP      = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMMON_ANODE = 1'd0,
		CFG_BRIGHTNESS   = 1'd1
	} cfg_reg_t;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] position;
		logic [7:0] char_code;
		logic       blank_others;
		logic [7:0] time_value;
		logic [7:0] dp_mode;
	} in_word_t;

	typedef struct packed {
		logic [3:0] digit_lines;
		logic [7:0] segment_lines;
	} out_word_t;

	// control from the input stage to the store and the scan logic
	typedef struct packed {
		logic     fire;
		in_word_t word;
	} stage_ctl_t;

	// segments a..g in bits 0..6
	function automatic logic [6:0] decode_char(input logic [7:0] c);
		logic [6:0] s;
		case (c)
			"0":     s = 7'h3F;
			"1":     s = 7'h06;
			"2":     s = 7'h5B;
			"3":     s = 7'h4F;
			"4":     s = 7'h66;
			"5":     s = 7'h6D;
			"6":     s = 7'h7D;
			"7":     s = 7'h07;
			"8":     s = 7'h7F;
			"9":     s = 7'h6F;
			"A":     s = 7'h77;
			"B":     s = 7'h7C;
			"C":     s = 7'h39;
			"D":     s = 7'h5E;
			"E":     s = 7'h79;
			"F":     s = 7'h71;
			"-":     s = 7'h40;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	// tens by reciprocal multiply, exact for all 8-bit values
	function automatic logic [4:0] tens_of(input logic [7:0] v);
		logic [15:0] prod;
		prod = 16'(v) * 16'd205;
		return prod[15:11];
	endfunction

	function automatic logic [3:0] units_of(input logic [7:0] v);
		logic [7:0] t10;
		logic [7:0] diff;
		t10  = 8'(tens_of(v)) * 8'd10;
		diff = v - t10;
		return diff[3:0];
	endfunction

endpackage

// File: hw/rtl/sssd_disp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_disp_store - digit characters and decimal points
// applies writes and gives the digit mask for the scanned segment
// ----------------------------------------------------------------------------
module sssd_disp_store (
	input  logic                clk,
	input  logic                arst_n,
	input  sssd_pkg::stage_ctl_t ctl,
	input  logic [2:0]          seg,
	output logic [3:0]          lit_mask
);
	import sssd_pkg::*;

	logic [7:0] char_q [NUM_DIGITS];
	logic [7:0] char_d [NUM_DIGITS];
	logic [1:0] dp_q;   // dp of digits 3 and 4
	logic [1:0] dp_d;
	logic [7:0] pattern [NUM_DIGITS];
	logic [1:0] pos_idx;
	logic [7:0] tens_char;
	logic [7:0] units_char;
	logic [4:0] tens;

	assign pos_idx    = 2'(ctl.word.position - 3'd1);
	assign tens       = tens_of(ctl.word.time_value);
	assign tens_char  = (tens > 5'd9) ? CHAR_SPACE : CHAR_ZERO + 8'(tens);
	assign units_char = CHAR_ZERO + 8'(units_of(ctl.word.time_value));

	always_comb begin
		char_d = char_q;
		dp_d   = dp_q;
		case (ctl.word.action)
			ACT_SET_CHAR: begin
				if (ctl.word.position inside {[3'd1:3'd4]}) begin
					if (ctl.word.blank_others) begin
						for (int k = 0; k < NUM_DIGITS; k++) char_d[k] = CHAR_SPACE;
					end
					char_d[pos_idx] = ctl.word.char_code;
				end
			end
			ACT_SET_HOURS: begin
				char_d[0] = tens_char;
				char_d[1] = units_char;
			end
			ACT_SET_MINUTES: begin
				char_d[2] = tens_char;
				char_d[3] = units_char;
			end
			ACT_SET_DP: begin
				dp_d[0] = (ctl.word.dp_mode == 8'd2) || (ctl.word.dp_mode == 8'd3);
				dp_d[1] = (ctl.word.dp_mode inside {[8'd1:8'd3]});
			end
			default: ;
		endcase
	end

	// digits 1 and 2 never get a lit dp
	always_comb begin
		pattern[0] = {1'b0, decode_char(char_d[0])};
		pattern[1] = {1'b0, decode_char(char_d[1])};
		pattern[2] = {dp_d[0], decode_char(char_d[2])};
		pattern[3] = {dp_d[1], decode_char(char_d[3])};
		for (int k = 0; k < NUM_DIGITS; k++) lit_mask[k] = pattern[k][seg];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_DIGITS; k++) char_q[k] <= CHAR_SPACE;
			dp_q <= 2'b00;
		end else if (ctl.fire) begin
			char_q <= char_d;
			dp_q   <= dp_d;
		end
	end

endmodule

// File: hw/rtl/sssd_scan_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_scan_ctl - segment scan counter and dwell timer
// holds each segment for the dwell set by the brightness level
// ----------------------------------------------------------------------------
module sssd_scan_ctl #(
	parameter int unsigned DWELL_MAX = sssd_pkg::DWELL_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          bright_wr,
	input  logic [sssd_pkg::CFG_DATA_W-1:0] bright_level,
	input  logic                          fire_tick,
	output logic [2:0]                    seg
);
	import sssd_pkg::*;

	localparam int unsigned CW = $clog2(DWELL_MAX + 1);

	logic [CW-1:0] dwell_tab [16];
	logic [CW-1:0] dwell_q;
	logic [CW-1:0] count_q;
	logic [2:0]    seg_q;
	logic [CW:0]   count_nxt;

	// dwell per level, levels above ten act as ten
	for (genvar g = 0; g < 16; g++) begin : g_dwell
		localparam int unsigned L = (g > 10) ? 10 : g;
		localparam int unsigned T = (L == 0) ? 1 : (L - 1) * (DWELL_MAX - 10) / 9 + 10;
		assign dwell_tab[g] = CW'(T);
	end

	assign count_nxt = {1'b0, count_q} + (CW+1)'(1);
	assign seg       = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= CW'(1);
			count_q <= '0;
			seg_q   <= 3'd0;
		end else begin
			if (bright_wr) dwell_q <= dwell_tab[bright_level];
			if (fire_tick) begin
				if (count_nxt >= {1'b0, dwell_q}) begin
					count_q <= '0;
					seg_q   <= seg_q + 3'd1;
				end else begin
					count_q <= count_nxt[CW-1:0];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_tick |=> $stable(seg_q))
		else $error("scan moved without a tick");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_tick |=> (count_q == '0 && seg_q == 3'($past(seg_q) + 3'd1)) ||
			(count_q == CW'($past(count_q) + CW'(1)) && seg_q == $past(seg_q)))
		else $error("tick did not step dwell or segment");

	a_dwell_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dwell_q != '0)
		else $error("dwell is zero");
`endif

endmodule

// File: hw/rtl/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver - four-digit seven-segment display scan driver
// one word in per tick or write, one word out with the pin levels
// ----------------------------------------------------------------------------
//
//  channel | signals                          | word
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data      | action and its fields
//  out     | out_valid, out_ready, out_data   | digit and segment pin levels
//  cfg     | cfg_valid, cfg_ready, cfg_index  | 0 common_anode, 1 brightness
//          | cfg_data                         |
//
//  one word accepted every cycle while the result is drained; each word passes the
//  input register, then the result register, and its result is set by the single
//  store update pass
//  reset clears the characters to space, the scan to segment a, dwell to one tick
//  out_ready low holds the result register; the input stage then fills and in_ready drops
//  cfg is always ready; a taken write goes straight into its register
//
module seven_segment_scan_driver #(
	parameter int unsigned DWELL_MAX = sssd_pkg::DWELL_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sssd_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sssd_pkg::out_word_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sssd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sssd_pkg::*;

	// input stage
	in_word_t   word_s1;
	logic       valid_s1;
	// result register
	out_word_t  out_q;
	logic       out_valid_q;
	// config
	logic       common_anode_q;

	logic       advance;
	logic       fire;
	logic       cfg_fire;
	stage_ctl_t ctl;
	logic [2:0] seg;
	logic [3:0] lit_mask;
	out_word_t  result;

	// result slot free or being drained this cycle
	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign ctl.fire = fire;
	assign ctl.word = word_s1;

	// characters and dp bits; mask uses the state after this word's write
	sssd_disp_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.seg      (seg),
		.lit_mask (lit_mask)
	);

	// scan position steps only on ticks, after the lines are taken
	sssd_scan_ctl #(
		.DWELL_MAX (DWELL_MAX)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.bright_wr    (cfg_fire && cfg_index == CFG_BRIGHTNESS),
		.bright_level (cfg_data),
		.fire_tick    (fire && word_s1.action == ACT_TICK),
		.seg          (seg)
	);

	// pin polarity
	always_comb begin
		if (common_anode_q) begin
			result.digit_lines   = lit_mask;
			result.segment_lines = ~(8'd1 << seg);
		end else begin
			result.digit_lines   = ~lit_mask;
			result.segment_lines = 8'd1 << seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			common_anode_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_fire && cfg_index == CFG_COMMON_ANODE) common_anode_q <= cfg_data[0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) word_s1 <= in_data;
		if (fire) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result slot");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed word produced no result");

	a_one_segment: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($onehot(out_q.segment_lines) || $onehot(~out_q.segment_lines)))
		else $error("more than one segment line driven");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("stalled word lost");
`endif

endmodule

// File: test/seven_segment_scan_driver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_tb - self-checking bench for the segment scan driver
// drives tick and write words with bursty valid and a stalling receiver, keeps
// its own copy of the character store, patterns and scan position, and checks
// every result word against the predicted pin levels in order
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_tb;

	import sssd_pkg::*;

	// action codes the block does not use, and the decimal point modes
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam logic [7:0] DP_OFF          = 8'd0;
	localparam logic [7:0] DP_LAST_ONLY    = 8'd1;
	localparam logic [7:0] DP_LAST_TWO     = 8'd2;
	localparam logic [7:0] DP_LAST_TWO_ALT = 8'd3;

	// brightness scale: levels above the top act as the top
	localparam int BRIGHT_TOP   = 10;
	localparam int DWELL_FLOOR  = 10;
	localparam int HOLD_CYCLES  = 120;
	localparam int SHOWN_LIMIT  = 10;
	localparam int SETTLE_TICKS = 10;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// bench copy of the display state
	logic [7:0] lit_pattern [NUM_DIGITS];
	logic [7:0] shown_char  [NUM_DIGITS];
	logic [2:0] scan_pos;
	logic [9:0] dwell_spent;
	logic       anode_mode;
	logic [3:0] bright_lvl;

	// pin levels still owed by the block, oldest first
	out_word_t expected_lines [$];
	out_word_t due_lines;
	int        fail_count;

	// sender burst state and receiver control
	int   burst_left;
	bit   no_gaps;
	bit   hold_req;
	int   stall_mode;
	int   stall_left;
	int   stall_period;
	int   stall_phase;

	string glyph_chars = "0123456789ABCDEF- ";

	seven_segment_scan_driver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// segments a..g in bits 0..6 for one character, anything unknown is dark
	function automatic logic [6:0] glyph_of(input logic [7:0] c);
		logic [6:0] hex_glyphs [16] = '{
			7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
			7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
		};
		if (c >= "0" && c <= "9")
			return hex_glyphs[4'(c - "0")];
		if (c >= "A" && c <= "F")
			return hex_glyphs[4'(c - "A" + 8'd10)];
		if (c == "-")
			return 7'h40;
		return 7'h00;
	endfunction

	// any character change redraws a..g of all digits, dp bits stay
	function automatic void redraw_digits();
		for (int k = 0; k < NUM_DIGITS; k++)
			lit_pattern[k] = {lit_pattern[k][7], glyph_of(shown_char[k])};
	endfunction

	function automatic void put_decimal(input logic [1:0] first, input logic [7:0] v);
		int tens;
		tens = v / 10;
		shown_char[first]        = (tens > 9) ? CHAR_SPACE : CHAR_ZERO + 8'(tens);
		shown_char[first + 2'd1] = CHAR_ZERO + 8'(v % 10);
		redraw_digits();
	endfunction

	function automatic int dwell_length(input logic [3:0] lvl);
		int l;
		if (lvl == 0)
			return 1;
		l = (lvl > BRIGHT_TOP) ? BRIGHT_TOP : int'(lvl);
		return (l - 1) * (int'(DWELL_MAX_DEF) - DWELL_FLOOR) / 9 + DWELL_FLOOR;
	endfunction

	// apply one word to the bench state and return the pin levels it shows
	function automatic out_word_t predict_lines(input in_word_t w);
		logic [3:0] lit;
		out_word_t  r;
		int         run;
		case (w.action)
			ACT_SET_CHAR: begin
				// positions outside 1..4 drop the whole word, blanking too
				if (w.position >= 1 && w.position <= NUM_DIGITS) begin
					if (w.blank_others)
						for (int k = 0; k < NUM_DIGITS; k++)
							shown_char[k] = CHAR_SPACE;
					shown_char[2'(w.position - 3'd1)] = w.char_code;
					redraw_digits();
				end
			end
			ACT_SET_HOURS:   put_decimal(2'd0, w.time_value);
			ACT_SET_MINUTES: put_decimal(2'd2, w.time_value);
			ACT_SET_DP: begin
				lit_pattern[2][7] = (w.dp_mode == DP_LAST_TWO || w.dp_mode == DP_LAST_TWO_ALT);
				lit_pattern[3][7] = (w.dp_mode >= DP_LAST_ONLY && w.dp_mode <= DP_LAST_TWO_ALT);
			end
			default: ;
		endcase
		for (int k = 0; k < NUM_DIGITS; k++)
			lit[k] = lit_pattern[k][scan_pos];
		if (anode_mode) begin
			r.digit_lines   = lit;
			r.segment_lines = ~(8'b1 << scan_pos);
		end else begin
			r.digit_lines   = ~lit;
			r.segment_lines = 8'b1 << scan_pos;
		end
		// only ticks move the scan; a shortened dwell takes effect on the next tick
		if (w.action == ACT_TICK) begin
			run = int'(dwell_spent) + 1;
			if (run >= dwell_length(bright_lvl)) begin
				dwell_spent = '0;
				scan_pos    = scan_pos + 3'd1;
			end else begin
				dwell_spent = 10'(run);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checking, sampled at the rising edge
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_lines.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOWN_LIMIT)
					$display("%t: unexpected word digits=%h segments=%h",
						$realtime, out_data.digit_lines, out_data.segment_lines);
			end else begin
				due_lines = expected_lines.pop_front();
				if (out_data.digit_lines !== due_lines.digit_lines ||
				    out_data.segment_lines !== due_lines.segment_lines) begin
					fail_count++;
					if (fail_count <= SHOWN_LIMIT)
						$display("%t: mismatch digits exp=%h got=%h segments exp=%h got=%h",
							$realtime, due_lines.digit_lines, out_data.digit_lines,
							due_lines.segment_lines, out_data.segment_lines);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: stall patterns, plus a long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		stall_left  = 0;
		stall_phase = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// keep out_ready low long enough for the pipe to back up
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end else begin
				if (stall_left == 0) begin
					stall_mode   = $urandom_range(0, 2);
					stall_left   = $urandom_range(20, 80);
					stall_period = $urandom_range(2, 5);
				end
				stall_left--;
				stall_phase++;
				case (stall_mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 2) != 0);
					default: out_ready <= (stall_phase % stall_period) != 0;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// sender helpers; every task returns right after a falling edge
	// ------------------------------------------------------------------

	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		expected_lines.push_back(predict_lines(w));
		@(negedge clk);
	endtask

	// wait until every owed word has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_COMMON_ANODE: anode_mode = val[0];
			CFG_BRIGHTNESS:   bright_lvl = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_word_t word_of(input logic [2:0] act, input logic [2:0] pos,
		input logic [7:0] ch, input logic blank, input logic [7:0] tv, input logic [7:0] dp);
		in_word_t w;
		w.action       = act;
		w.position     = pos;
		w.char_code    = ch;
		w.blank_others = blank;
		w.time_value   = tv;
		w.dp_mode      = dp;
		return w;
	endfunction

	// mostly legal values, with full-range noise in every field
	function automatic in_word_t random_word();
		in_word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)      w.action = ACT_TICK;
		else if (pick < 65) w.action = ACT_SET_CHAR;
		else if (pick < 73) w.action = ACT_SET_HOURS;
		else if (pick < 81) w.action = ACT_SET_MINUTES;
		else if (pick < 93) w.action = ACT_SET_DP;
		else                w.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		w.position     = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) :
			$urandom_range(1, 4));
		w.char_code    = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			32'(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)]));
		w.blank_others = 1'($urandom_range(0, 1));
		w.time_value   = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 99));
		w.dp_mode      = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 4));
		return w;
	endfunction

	task automatic send_ticks(input int n);
		in_word_t w;
		repeat (n) begin
			w = random_word();
			w.action = ACT_TICK;
			send_word(w);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// blank display after reset, cathode polarity, one-tick dwell
	task automatic test_power_on();
		send_ticks(3);
	endtask

	// glyphs, blanking, dropped positions; brightness 0 walks a segment per tick
	task automatic test_char_writes();
		send_word(word_of(ACT_SET_CHAR, 3'd1, "8", 1'b1, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_CHAR, 3'd2, "A", 1'b0, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_CHAR, 3'd3, "-", 1'b0, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_CHAR, 3'd4, "F", 1'b0, 8'd0, 8'd0));
		send_ticks(8);
		// out-of-range positions must not blank anything
		send_word(word_of(ACT_SET_CHAR, 3'd0, "1", 1'b1, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_CHAR, 3'd5, "2", 1'b1, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_CHAR, 3'd7, "3", 1'b1, 8'd0, 8'd0));
		// lowercase and high codes are dark
		send_word(word_of(ACT_SET_CHAR, 3'd4, "a", 1'b0, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_CHAR, 3'd2, 8'hFF, 1'b0, 8'd0, 8'd0));
	endtask

	// tens above nine go blank, decimal point modes, spare action codes
	task automatic test_time_and_dp();
		send_word(word_of(ACT_SET_HOURS, 3'd0, 8'd0, 1'b0, 8'd255, 8'd0));
		send_word(word_of(ACT_SET_HOURS, 3'd0, 8'd0, 1'b0, 8'd100, 8'd0));
		send_word(word_of(ACT_SET_MINUTES, 3'd0, 8'd0, 1'b0, 8'd99, 8'd0));
		send_word(word_of(ACT_SET_MINUTES, 3'd0, 8'd0, 1'b0, 8'd0, 8'd0));
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, DP_LAST_ONLY));
		send_ticks(7);
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, DP_LAST_TWO));
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, DP_LAST_TWO_ALT));
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, 8'd255));
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, DP_OFF));
		send_word(word_of(ACT_SPARE_FIRST, 3'd1, "8", 1'b1, 8'd88, DP_LAST_TWO));
		send_word(word_of(ACT_SPARE_LAST, 3'd4, "0", 1'b1, 8'd11, DP_LAST_ONLY));
	endtask

	// anode polarity flips both line groups
	task automatic test_polarity();
		write_reg(CFG_COMMON_ANODE, 4'd1);
		send_word(word_of(ACT_SET_HOURS, 3'd0, 8'd0, 1'b0, 8'd12, 8'd0));
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, DP_LAST_TWO));
		send_ticks(9);
		write_reg(CFG_COMMON_ANODE, 4'd0);
		send_ticks(3);
	endtask

	// full dwell counter, clamp above level ten, dwell shortened mid-segment
	task automatic test_long_dwell();
		write_reg(CFG_BRIGHTNESS, 4'd10);
		send_word(word_of(ACT_SET_MINUTES, 3'd0, 8'd0, 1'b0, 8'd47, 8'd0));
		send_word(word_of(ACT_SET_DP, 3'd0, 8'd0, 1'b0, 8'd0, DP_LAST_TWO));
		send_ticks(500);
		// level fifteen acts as ten, so the segment moves after 500 more ticks
		write_reg(CFG_BRIGHTNESS, 4'd15);
		send_ticks(510);
		write_reg(CFG_BRIGHTNESS, 4'd11);
		send_ticks(5);
		write_reg(CFG_BRIGHTNESS, 4'd1);
		send_ticks(30);
		write_reg(CFG_BRIGHTNESS, 4'd0);
		send_ticks(5);
	endtask

	// receiver holds off while the sender keeps offering, input must back up
	task automatic test_backpressure();
		hold_req   = 1'b1;
		no_gaps    = 1'b1;
		burst_left = 0;
		repeat (60)
			send_word(random_word());
		no_gaps = 1'b0;
	endtask

	// random words under a handful of polarity and brightness settings
	task automatic test_random_mix();
		int lvl_pick;
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(CFG_COMMON_ANODE, 4'($urandom_range(0, 1)));
			lvl_pick = $urandom_range(0, 5);
			// short dwells so the scan moves; now and then any level
			write_reg(CFG_BRIGHTNESS,
				4'((lvl_pick < 5) ? (lvl_pick % 3) : $urandom_range(0, 15)));
			repeat (25)
				send_word(random_word());
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_COMMON_ANODE;
		cfg_data   = '0;
		fail_count = 0;
		burst_left = 0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			lit_pattern[k] = 8'h00;
			shown_char[k]  = CHAR_SPACE;
		end
		scan_pos    = '0;
		dwell_spent = '0;
		anode_mode  = 1'b0;
		bright_lvl  = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_power_on();
		test_char_writes();
		test_time_and_dp();
		test_polarity();
		test_long_dwell();
		test_backpressure();
		test_random_mix();

		drain();
		// then watch for any stray word
		repeat (SETTLE_TICKS) @(posedge clk);
		if (fail_count == 0 && expected_lines.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
